### design/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants for the RGB to HSL converter
// Holds the divider lane layout handed from cell to cell and fixed scale
// factors used by the front stage.
// ----------------------------------------------------------------------------
package rhc_pkg;

   localparam int unsigned ChanW    = 8;
   localparam int unsigned HueW     = 9;
   localparam int unsigned PctW     = 7;
   localparam int unsigned RemW     = 17;
   localparam int unsigned QuoW     = 9;
   // one quotient bit per cell
   localparam int unsigned CellCount = QuoW;

   localparam logic [8:0]  FullScale  = 9'd255;
   localparam logic [8:0]  LightDiv   = 9'd510;
   localparam logic [RemW-1:0] Percent   = RemW'(100);
   localparam logic [RemW-1:0] DegSector = RemW'(60);

   // lightness = (sum * LightMul) >> LightShift, exact floor(100*sum/510)
   // for every sum in 0..510
   localparam logic [12:0]  LightMul   = 13'd6426;
   localparam int unsigned  LightShift = 15;

   // one restoring divider lane: partial remainder, shifted divisor, quotient
   typedef struct packed {
      logic [RemW-1:0] rem;
      logic [RemW-1:0] dsh;
      logic [QuoW-1:0] quo;
   } lane_type;

   // lightness is finished in the front stage and rides along the chain
   typedef struct packed {
      lane_type        hue;
      lane_type        sat;
      logic [PctW-1:0] lgt;
   } stage_type;

endpackage

### design/rhc_front.sv
// ----------------------------------------------------------------------------
// rhc_front: pixel front stage
// Finds max/min, forms the hue and saturation dividends and divisors,
// scales lightness by a reciprocal multiply and registers the first beat.
// ----------------------------------------------------------------------------
module rhc_front import rhc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [ChanW-1:0] red,
   input  logic [ChanW-1:0] green,
   input  logic [ChanW-1:0] blue,
   output logic             out_valid,
   input  logic             out_ready,
   output stage_type        out_data
);

   logic            valid_ff;
   stage_type       data_ff;
   stage_type       data_in;
   logic [ChanW-1:0] hi;
   logic [ChanW-1:0] lo;
   logic [ChanW-1:0] d;
   logic [8:0]      sum;
   logic [8:0]      sat_div;
   logic [11:0]     t;
   logic [21:0]     light_prod;
   logic            gray;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      hi = red;
      lo = red;
      if (green > hi) hi = green;
      if (blue > hi)  hi = blue;
      if (green < lo) lo = green;
      if (blue < lo)  lo = blue;
      d    = hi - lo;
      sum  = {1'b0, hi} + {1'b0, lo};
      gray = (d == '0);

      // hue numerator over 60, already folded into 0..6*d
      if (blue == hi) begin
         t = 12'({d, 2'b00}) + 12'(red) - 12'(green);
      end else if (green == hi) begin
         t = 12'({d, 1'b0}) + 12'(blue) - 12'(red);
      end else if (green >= blue) begin
         t = 12'(green) - 12'(blue);
      end else begin
         // wrap negative hue by a full turn (6 sectors)
         t = 12'({d, 2'b00}) + 12'({d, 1'b0}) + 12'(green) - 12'(blue);
      end

      sat_div = (sum < FullScale) ? sum : (LightDiv - sum);

      light_prod = 22'(sum) * 22'(LightMul);

      data_in.hue.rem = gray ? '0 : RemW'(t) * DegSector;
      data_in.hue.dsh = gray ? (RemW'(1) << (QuoW-1)) : (RemW'(d) << (QuoW-1));
      data_in.hue.quo = '0;
      data_in.sat.rem = gray ? '0 : RemW'(d) * Percent;
      data_in.sat.dsh = gray ? (RemW'(1) << (QuoW-1)) : (RemW'(sat_div) << (QuoW-1));
      data_in.sat.quo = '0;
      data_in.lgt     = light_prod[LightShift +: PctW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### design/rhc_cell.sv
// ----------------------------------------------------------------------------
// rhc_cell: one restoring division step
// Produces one quotient bit on the hue and saturation lanes, carries the
// lightness along and hands the beat to the next cell.
// ----------------------------------------------------------------------------
module rhc_cell import rhc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  stage_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output stage_type out_data
);

   logic      valid_ff;
   stage_type data_ff;
   stage_type data_in;

   function automatic lane_type step_lane(input lane_type x);
      lane_type y;
      logic     ge;
      ge    = (x.rem >= x.dsh);
      y.rem = ge ? (x.rem - x.dsh) : x.rem;
      y.dsh = x.dsh >> 1;
      y.quo = {x.quo[QuoW-2:0], ge};
      return y;
   endfunction

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      data_in.hue = step_lane(in_data.hue);
      data_in.sat = step_lane(in_data.sat);
      data_in.lgt = in_data.lgt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### design/rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter: 8-bit RGB pixel to hue/saturation/lightness
// Pipeline: 1 front stage + 9 cells, each registered, from req beat to rsp valid.
// Throughput: one pixel per cycle while rsp_ready holds; each cell resolves one quotient bit.
// Stalls: a held rsp beat lets bubbles upstream fill before req_ready drops.
// Reset: synchronous, clears all valid flags; payload registers not reset.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter import rhc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [ChanW-1:0] req_red,
   input  logic [ChanW-1:0] req_green,
   input  logic [ChanW-1:0] req_blue,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [HueW-1:0]  rsp_hue,
   output logic [PctW-1:0]  rsp_saturation,
   output logic [PctW-1:0]  rsp_lightness
);

   // Chain node k is the output of stage k: node 0 is the front stage,
   // node CellCount is the last cell, whose register is the rsp register.
   logic      vld [CellCount+1];
   logic      rdy [CellCount+1];
   stage_type dat [CellCount+1];

   // Front: max/min, dividends and pre-shifted divisors for two lanes
   // (hue: 60*(sector*d + diff) / d, saturation: 100*d / (sum or 510-sum)).
   // Lightness 100*sum / 510 is a reciprocal multiply here and rides along.
   // A gray pixel divides 0 by 1.
   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .out_valid (vld[0]),
      .out_ready (rdy[0]),
      .out_data  (dat[0])
   );

   // Divider row: every cell compares remainder with its shifted divisor,
   // emits one quotient bit MSB first and halves the divisor.
   for (genvar k = 0; k < CellCount; k++) begin : g_cell
      rhc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[k]),
         .in_ready  (rdy[k]),
         .in_data   (dat[k]),
         .out_valid (vld[k+1]),
         .out_ready (rdy[k+1]),
         .out_data  (dat[k+1])
      );
   end

   assign rdy[CellCount]  = rsp_ready;
   assign rsp_valid       = vld[CellCount];
   assign rsp_hue         = dat[CellCount].hue.quo[HueW-1:0];
   assign rsp_saturation  = dat[CellCount].sat.quo[PctW-1:0];
   assign rsp_lightness   = dat[CellCount].lgt;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_hue_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue < HueW'(360)))
      else $error("hue out of range");

   a_pct_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_saturation <= PctW'(100)) && (rsp_lightness <= PctW'(100))))
      else $error("percent out of range");

   a_ready_chain : assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("req_ready low while rsp side drains");

   // a stalled rsp beat stays put until taken
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable({rsp_hue, rsp_saturation, rsp_lightness})))
      else $error("rsp beat dropped or changed while stalled");

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for rgb_to_hsl_converter
// Sends 8-bit RGB pixels over the req channel with random gaps and stalls.
// A scoreboard works out hue, saturation and lightness for each accepted
// pixel and checks every rsp beat, in order, field by field.
// ----------------------------------------------------------------------------
module tb_top import rhc_pkg::*; ();

   localparam int unsigned CycleLimit     = 200000;
   localparam int unsigned DrainCycles    = 30;   // margin after the last result, leave room
   localparam int unsigned RandomPerPhase = 400;
   localparam int unsigned HoldCycles     = 300;  // long rsp back-pressure
   localparam int unsigned MaxReports     = 100;  // keep the log short

   typedef struct packed {
      logic [HueW-1:0] hue;
      logic [PctW-1:0] sat;
      logic [PctW-1:0] light;
   } hsl_pixel_type;

   // -------------------------------------------------------------------------
   // Scoreboard: one expected HSL triple per accepted pixel, oldest first.
   // -------------------------------------------------------------------------
   class hsl_scoreboard_type;
      hsl_pixel_type expected_q[$];
      int unsigned noted;
      int unsigned checked;
      int unsigned mismatches;

      // Exact integer form of the conversion; every quotient is a floor of
      // a non-negative value.
      function void note_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                               logic [ChanW-1:0] b);
         int ri, gi, bi, hi, lo, d, sum, num;
         hsl_pixel_type p;
         ri = r;
         gi = g;
         bi = b;
         hi = ri;
         lo = ri;
         if (gi > hi) hi = gi;
         if (bi > hi) hi = bi;
         if (gi < lo) lo = gi;
         if (bi < lo) lo = bi;
         d   = hi - lo;
         sum = hi + lo;
         p.light = PctW'((100 * sum) / 510);
         p.hue   = '0;
         p.sat   = '0;
         if (d != 0) begin
            // above mid-gray the divisor flips to the distance from white
            if (sum < 255) p.sat = PctW'((100 * d) / sum);
            else           p.sat = PctW'((100 * d) / (510 - sum));
            // blue wins ties over green, green over red
            if (bi == hi)      num = 60 * (4 * d + (ri - gi));
            else if (gi == hi) num = 60 * (2 * d + (bi - ri));
            else               num = 60 * (gi - bi);
            // red sector with green below blue wraps into 300..359
            if (num < 0) num += 360 * d;
            p.hue = HueW'(num / d);
         end
         expected_q.push_back(p);
         noted++;
      endfunction

      function void check_pixel(hsl_pixel_type got);
         hsl_pixel_type want;
         checked++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("%0t: rsp beat with nothing expected: hue %0d sat %0d light %0d",
                        $time, got.hue, got.sat, got.light);
            return;
         end
         want = expected_q.pop_front();
         if (got.hue != want.hue) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("%0t: hue mismatch, expected %0d actual %0d",
                        $time, want.hue, got.hue);
         end
         if (got.sat != want.sat) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("%0t: saturation mismatch, expected %0d actual %0d",
                        $time, want.sat, got.sat);
         end
         if (got.light != want.light) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("%0t: lightness mismatch, expected %0d actual %0d",
                        $time, want.light, got.light);
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [ChanW-1:0] req_red = '0;
   logic [ChanW-1:0] req_green = '0;
   logic [ChanW-1:0] req_blue = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [HueW-1:0]  rsp_hue;
   logic [PctW-1:0]  rsp_saturation;
   logic [PctW-1:0]  rsp_lightness;

   int unsigned send_idle_pct = 0;   // chance per cycle that req goes quiet
   int unsigned recv_idle_pct = 0;   // chance per cycle that rsp_ready drops
   int unsigned hold_left     = 0;   // owned by the rsp process
   int unsigned cycle_count   = 0;

   hsl_scoreboard_type board = new();

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rgb_to_hsl_converter u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_lightness  (rsp_lightness)
   );

   // -------------------------------------------------------------------------
   // req side. Called at a rising edge; returns at the edge that took the beat.
   // All drives are nonblocking, and each edge sees at most one write to
   // req_valid, so back-to-back beats keep valid high without a glitch.
   // -------------------------------------------------------------------------
   task automatic send_pixel(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                             input logic [ChanW-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      // inputs and outputs still hold their pre-edge values here
      while (!req_ready) @(posedge clock);
      board.note_pixel(r, g, b);
   endtask

   // About three in eight pixels are uniform; the rest force ties, grays and near-grays so the
   // sector priority and the d = 0 path get exercised often.
   task automatic send_random(input int unsigned count);
      logic [ChanW-1:0] r, g, b;
      for (int unsigned i = 0; i < count; i++) begin
         r = ChanW'($urandom);
         g = ChanW'($urandom);
         b = ChanW'($urandom);
         case ($urandom_range(7))
            0: g = r;                                    // red/green tie
            1: b = g;                                    // green/blue tie
            2: b = r;                                    // red/blue tie
            3: begin g = r; b = r; end                   // gray
            4: begin                                     // near gray
               g = r ^ ChanW'($urandom_range(3));
               b = r ^ ChanW'($urandom_range(3));
            end
            default: ;
         endcase
         send_pixel(r, g, b);
      end
   endtask

   // -------------------------------------------------------------------------
   // rsp side: random ready, plus two long holds that back the pipe up until
   // req_ready drops while the sender keeps offering pixels.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            board.check_pixel({rsp_hue, rsp_saturation, rsp_lightness});
            if (board.checked == 300 || board.checked == 1000) hold_left = HoldCycles;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, board.pending());
         $display("== FAIL ==");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   // corners packed as {red, green, blue}
   logic [23:0] corners [$] = '{
      24'h000000,   // black
      24'hFFFFFF,   // white
      24'h808080,   // mid gray
      24'h010101,   // near-black gray
      24'hFF0000,   // pure red
      24'h00FF00,   // pure green
      24'h0000FF,   // pure blue
      24'hFFFF00,   // yellow: red/green tie goes to green
      24'h00FFFF,   // cyan: green/blue tie goes to blue
      24'hFF00FF,   // magenta: red/blue tie goes to blue
      24'hFF0001,   // red max, green below blue: hue wraps to 359
      24'hC8000A,   // wrap with a wider gap
      24'hFF0AC8,   // wrap, near magenta
      24'hFE0000,   // M+m just under 255
      24'h807F7F,   // M+m exactly 255, switches the saturation divisor
      24'h7F7E7E,   // M+m just under 255, small d
      24'hFFFEFE,   // near white, d = 1
      24'h010000,   // near black, red
      24'h000100,   // near black, green
      24'h000001,   // near black, blue
      24'hAA5500,   // mid hue in red sector
      24'h2040C0,   // blue sector
      24'h40C020    // green sector
   };

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // phase 1: sender idles lightly, receiver heavily
      send_idle_pct = 31;
      recv_idle_pct = 66;
      foreach (corners[i]) send_pixel(corners[i][23:16], corners[i][15:8], corners[i][7:0]);
      send_random(RandomPerPhase);

      // phase 2: the other way round
      send_idle_pct = 66;
      recv_idle_pct = 31;
      send_random(RandomPerPhase);

      // phase 3: full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(RandomPerPhase);
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("%0d pixels sent, %0d results checked, %0d field mismatches",
               board.noted, board.checked, board.mismatches);
      $display("covered gray, tie, wrapped-hue and divisor corners, three idle mixes, two stalls");
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
